@@ sv/sata_csi_pkg.sv @@
// ----------------------------------------------------------------------------
// sata_csi_pkg
// Shared types and constants of the command slot issuer: operation and
// result codes, the sequencer states, the FIS and header constants and
// the result record passed to the output register.
// ----------------------------------------------------------------------------
package sata_csi_pkg;

    localparam int MAX_SLOTS_DEF = 32;
    localparam int SLOT_W        = 5;
    localparam int CNT_W         = 6;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;
    localparam logic [1:0] OP_CHECK = 2'd3;

    localparam logic [16:0] HDR_FIS_LEN = 17'h00005;
    localparam logic [16:0] HDR_ONE_PRD = 17'h10000;
    localparam logic [16:0] HDR_WRITE   = 17'h00040;

    localparam logic [7:0] CMD_READ_EXT  = 8'h25;
    localparam logic [7:0] CMD_WRITE_EXT = 8'h35;
    localparam logic [7:0] CMD_FLUSH_EXT = 8'hEA;
    localparam logic [7:0] DEV_LBA       = 8'h50;

    typedef enum logic [1:0] {
        KIND_ISSUED,
        KIND_NO_SLOT,
        KIND_DONE,
        KIND_NONE
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RECOUNT,
        ST_ISSUE,
        ST_RETIRE
    } t_state;

    typedef struct packed {
        t_kind              kind;
        logic [SLOT_W-1:0]  slot;
        logic [16:0]        header_flags;
        logic [21:0]        prd_byte_count;
        logic [7:0]         ata_command;
        logic [15:0]        fis_count;
        logic [47:0]        lba;
        logic [7:0]         fis_device;
        logic               fis_feature;
        logic [CNT_W-1:0]   slots_free;
        logic               last;
    } t_result;

endpackage

@@ sv/sata_csi_lowbit.sv @@
// ----------------------------------------------------------------------------
// sata_csi_lowbit
// Shared find-lowest-set-bit unit: gives the index of the lowest set bit
// of the working vector and the vector with that bit cleared.
// ----------------------------------------------------------------------------
module sata_csi_lowbit #(
    parameter int WIDTH = sata_csi_pkg::MAX_SLOTS_DEF
) (
    input  logic [WIDTH-1:0]                i_vec,
    output logic                            o_found,
    output logic [sata_csi_pkg::SLOT_W-1:0] o_index,
    output logic [WIDTH-1:0]                o_rest
);

    always_comb begin
        o_index = '0;
        for (int i = WIDTH - 1; i >= 0; i--) begin
            if (i_vec[i]) begin
                o_index = sata_csi_pkg::SLOT_W'(i);
            end
        end
    end

    assign o_found = |i_vec;
    assign o_rest  = i_vec & (i_vec - WIDTH'(1));

endmodule

@@ sv/sata_csi_outreg.sv @@
// ----------------------------------------------------------------------------
// sata_csi_outreg
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module sata_csi_outreg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  sata_csi_pkg::t_result i_data,
    input  logic                  i_stall,
    output logic                  o_room,
    output logic                  o_valid,
    output sata_csi_pkg::t_result o_data
);

    logic                  r_valid;
    sata_csi_pkg::t_result r_data;

    assign o_room  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

endmodule

@@ sv/sata_command_slot_issuer.sv @@
// ----------------------------------------------------------------------------
// sata_command_slot_issuer
// Command slot tracking for one port: allocates the lowest free slot for
// read, write and flush requests and builds the command fields; retires
// completed slots one per result from the command-issue register.
//
//   channel  direction  handshake                  payload
//   in       input      i_in_valid / o_in_stall    operation, offset, count, mask
//   out      output     o_out_valid / i_out_stall  kind .. last
//   cfg      input      i_cfg_valid / o_cfg_ready  slot count
//
// a request is captured, then takes one pass of the lowest-bit unit
// a completion check gives one result per retired slot, or one if none retires
// a slot count write is followed by a recount of free slots, one active slot
// of the new window per pass through the same lowest-bit unit
// reset leaves 32 (MAX_SLOTS) free slots and none active
// a stalled output holds the sequencer until the result is taken
// ----------------------------------------------------------------------------
module sata_command_slot_issuer #(
    parameter int MAX_SLOTS = sata_csi_pkg::MAX_SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_operation,
    input  logic [56:0]                     i_byte_offset,
    input  logic [22:0]                     i_byte_count,
    input  logic [31:0]                     i_issued_mask,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [1:0]                      o_kind,
    output logic [sata_csi_pkg::SLOT_W-1:0] o_slot,
    output logic [16:0]                     o_header_flags,
    output logic [21:0]                     o_prd_byte_count,
    output logic [7:0]                      o_ata_command,
    output logic [15:0]                     o_fis_count,
    output logic [47:0]                     o_lba,
    output logic [7:0]                      o_fis_device,
    output logic                            o_fis_feature,
    output logic [sata_csi_pkg::CNT_W-1:0]  o_slots_free,
    output logic                            o_last,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [sata_csi_pkg::CNT_W-1:0]  i_cfg_data
);

    localparam int CW = sata_csi_pkg::CNT_W;

    sata_csi_pkg::t_state  r_state, n_state;
    logic [CW-1:0]         r_slot_count, n_slot_count;
    logic [CW-1:0]         r_free, n_free;
    logic [MAX_SLOTS-1:0]  r_active, n_active;
    logic [MAX_SLOTS-1:0]  r_work, n_work;
    logic [1:0]            r_op, n_op;
    logic [22:0]           r_bytes, n_bytes;
    logic [47:0]           r_lba, n_lba;

    logic                            w_found;
    logic [sata_csi_pkg::SLOT_W-1:0] w_low_idx;
    logic [MAX_SLOTS-1:0]            w_rest;
    logic [MAX_SLOTS-1:0]            w_bit;
    logic                            w_room;
    logic                            w_load;
    sata_csi_pkg::t_result           w_res;
    sata_csi_pkg::t_result           w_out;
    logic                            w_in_fire;
    logic                            w_cfg_fire;
    logic [CW-1:0]                   w_cfg_n;
    logic [22:0]                     w_bytes_m1;

    function automatic logic [MAX_SLOTS-1:0] f_window(input logic [CW-1:0] n);
        logic [MAX_SLOTS-1:0] w;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            w[i] = (CW'(i) < n);
        end
        return w;
    endfunction

    sata_csi_lowbit #(
        .WIDTH (MAX_SLOTS)
    ) u_lowbit (
        .i_vec   (r_work),
        .o_found (w_found),
        .o_index (w_low_idx),
        .o_rest  (w_rest)
    );

    sata_csi_outreg u_outreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_data  (w_res),
        .i_stall (i_out_stall),
        .o_room  (w_room),
        .o_valid (o_out_valid),
        .o_data  (w_out)
    );

    assign o_cfg_ready = (r_state == sata_csi_pkg::ST_IDLE);
    assign o_in_stall  = (r_state != sata_csi_pkg::ST_IDLE) || i_cfg_valid;
    assign w_cfg_fire  = i_cfg_valid && o_cfg_ready;
    assign w_in_fire   = i_in_valid && !o_in_stall;
    assign w_bit       = r_work ^ w_rest;
    assign w_bytes_m1  = r_bytes - 23'd1;

    always_comb begin
        if (i_cfg_data == '0) begin
            w_cfg_n = CW'(1);
        end else if (i_cfg_data > CW'(MAX_SLOTS)) begin
            w_cfg_n = CW'(MAX_SLOTS);
        end else begin
            w_cfg_n = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sata_csi_pkg::ST_IDLE;
            r_slot_count <= CW'(MAX_SLOTS);
            r_free       <= CW'(MAX_SLOTS);
            r_active     <= '0;
            r_work       <= '0;
        end else begin
            r_state      <= n_state;
            r_slot_count <= n_slot_count;
            r_free       <= n_free;
            r_active     <= n_active;
            r_work       <= n_work;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_bytes <= n_bytes;
        r_lba   <= n_lba;
    end

    always_comb begin
        n_state      = r_state;
        n_slot_count = r_slot_count;
        n_free       = r_free;
        n_active     = r_active;
        n_work       = r_work;
        n_op         = r_op;
        n_bytes      = r_bytes;
        n_lba        = r_lba;
        w_load       = 1'b0;
        w_res        = '0;

        unique case (r_state)
            sata_csi_pkg::ST_IDLE: begin
                if (w_cfg_fire) begin
                    n_slot_count = w_cfg_n;
                    n_free       = w_cfg_n;
                    n_work       = r_active & f_window(w_cfg_n);
                    n_state      = sata_csi_pkg::ST_RECOUNT;
                end else if (w_in_fire) begin
                    n_op    = i_operation;
                    n_bytes = i_byte_count;
                    n_lba   = i_byte_offset[56:9];
                    if (i_operation == sata_csi_pkg::OP_CHECK) begin
                        if ((r_active != '0) && (r_free != r_slot_count)) begin
                            n_work = r_active & ~i_issued_mask[MAX_SLOTS-1:0];
                        end else begin
                            n_work = '0;
                        end
                        n_state = sata_csi_pkg::ST_RETIRE;
                    end else begin
                        if (r_free == '0) begin
                            n_work = '0;
                        end else begin
                            n_work = ~r_active & f_window(r_slot_count);
                        end
                        n_state = sata_csi_pkg::ST_ISSUE;
                    end
                end
            end
            sata_csi_pkg::ST_RECOUNT: begin
                if (w_found) begin
                    n_work = w_rest;
                    n_free = r_free - CW'(1);
                end else begin
                    n_state = sata_csi_pkg::ST_IDLE;
                end
            end
            sata_csi_pkg::ST_ISSUE: begin
                if (w_room) begin
                    w_load     = 1'b1;
                    w_res.last = 1'b1;
                    n_state    = sata_csi_pkg::ST_IDLE;
                    if (w_found) begin
                        n_free           = r_free - CW'(1);
                        n_active         = r_active | w_bit;
                        w_res.kind       = sata_csi_pkg::KIND_ISSUED;
                        w_res.slot       = w_low_idx;
                        w_res.slots_free = r_free - CW'(1);
                        if (r_op == sata_csi_pkg::OP_FLUSH) begin
                            w_res.header_flags = sata_csi_pkg::HDR_FIS_LEN;
                            w_res.ata_command  = sata_csi_pkg::CMD_FLUSH_EXT;
                        end else begin
                            w_res.header_flags = sata_csi_pkg::HDR_ONE_PRD
                                | sata_csi_pkg::HDR_FIS_LEN
                                | ((r_op == sata_csi_pkg::OP_WRITE)
                                   ? sata_csi_pkg::HDR_WRITE : 17'd0);
                            w_res.ata_command  = (r_op == sata_csi_pkg::OP_WRITE)
                                ? sata_csi_pkg::CMD_WRITE_EXT
                                : sata_csi_pkg::CMD_READ_EXT;
                            w_res.prd_byte_count = w_bytes_m1[21:0];
                            w_res.fis_count      = {2'b00, r_bytes[22:9]};
                            w_res.lba            = r_lba;
                            w_res.fis_device     = sata_csi_pkg::DEV_LBA;
                            w_res.fis_feature    = 1'b1;
                        end
                    end else begin
                        w_res.kind       = sata_csi_pkg::KIND_NO_SLOT;
                        w_res.slots_free = r_free;
                    end
                end
            end
            sata_csi_pkg::ST_RETIRE: begin
                if (w_room) begin
                    w_load = 1'b1;
                    if (w_found) begin
                        n_work   = w_rest;
                        n_active = r_active & ~w_bit;
                        if (r_free < r_slot_count) begin
                            n_free = r_free + CW'(1);
                        end
                        w_res.kind       = sata_csi_pkg::KIND_DONE;
                        w_res.slot       = w_low_idx;
                        w_res.slots_free = n_free;
                        w_res.last       = (w_rest == '0);
                        if (w_rest == '0) begin
                            n_state = sata_csi_pkg::ST_IDLE;
                        end
                    end else begin
                        w_res.kind       = sata_csi_pkg::KIND_NONE;
                        w_res.slots_free = r_free;
                        w_res.last       = 1'b1;
                        n_state          = sata_csi_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = sata_csi_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_kind           = w_out.kind;
    assign o_slot           = w_out.slot;
    assign o_header_flags   = w_out.header_flags;
    assign o_prd_byte_count = w_out.prd_byte_count;
    assign o_ata_command    = w_out.ata_command;
    assign o_fis_count      = w_out.fis_count;
    assign o_lba            = w_out.lba;
    assign o_fis_device     = w_out.fis_device;
    assign o_fis_feature    = w_out.fis_feature;
    assign o_slots_free     = w_out.slots_free;
    assign o_last           = w_out.last;

`ifndef ASSERT_OFF
    a_free_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= r_slot_count)
        else $error("free slot count above slot count");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_slot_count != '0) && (r_slot_count <= CW'(MAX_SLOTS)))
        else $error("slot count out of range");

    a_issue_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sata_csi_pkg::ST_ISSUE) && w_load && w_found
        |-> !r_active[w_low_idx] ##1 r_active[$past(w_low_idx)])
        else $error("issued slot was busy or not marked active");

    a_retire_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sata_csi_pkg::ST_RETIRE) && w_load && w_found
        |-> r_active[w_low_idx])
        else $error("retired slot was not active");
`endif

endmodule
